// File: rtl/rpn_pkg.sv
// Package for the RPN stack evaluator: token and result types, command and
// status codes, sizing constants and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package rpn_pkg;

  // Sizing
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  // Command codes
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_BADDEPTH  = 3'd4;

  // Input token
  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] number;
    logic                     last_token;
  } in_t;

  // Result of one expression
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } out_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Microcode addresses
  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_DECODE   = 4'd1,
    U_PUSH     = 4'd2,
    U_UNDER    = 4'd3,
    U_RD_B     = 4'd4,
    U_RD_A     = 4'd5,
    U_ALU      = 4'd6,
    U_DIV_CHK  = 4'd7,
    U_DIV_WAIT = 4'd8,
    U_WRB      = 4'd9,
    U_END      = 4'd10,
    U_FIN      = 4'd11
  } uaddr_e;

  // Datapath action of one step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PUSH,
    ACT_UNDER,
    ACT_RD_B,
    ACT_RD_A,
    ACT_ALU,
    ACT_DIV_CHK,
    ACT_DIV_CAP,
    ACT_WRB,
    ACT_RD_TOP,
    ACT_EMIT
  } act_e;

  // Jump conditions: true selects target, false selects next
  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_IN_FIRE,
    JC_DISPATCH,
    JC_IS_DIV,
    JC_B_ZERO,
    JC_DIV_DONE,
    JC_LAST,
    JC_OUT_FREE
  } jc_e;

  typedef struct packed {
    act_e   act;
    jc_e    jc;
    uaddr_e target;
    uaddr_e next;
  } ucw_t;

  // Microcode ROM
  function automatic ucw_t ucode(uaddr_e addr);
    ucw_t w;
    unique case (addr)
      U_IDLE:     w = '{ACT_LATCH,   JC_IN_FIRE,  U_DECODE,   U_IDLE};
      U_DECODE:   w = '{ACT_NONE,    JC_DISPATCH, U_END,      U_END};
      U_PUSH:     w = '{ACT_PUSH,    JC_ALWAYS,   U_END,      U_END};
      U_UNDER:    w = '{ACT_UNDER,   JC_ALWAYS,   U_END,      U_END};
      U_RD_B:     w = '{ACT_RD_B,    JC_ALWAYS,   U_RD_A,     U_RD_A};
      U_RD_A:     w = '{ACT_RD_A,    JC_ALWAYS,   U_ALU,      U_ALU};
      U_ALU:      w = '{ACT_ALU,     JC_IS_DIV,   U_DIV_CHK,  U_WRB};
      U_DIV_CHK:  w = '{ACT_DIV_CHK, JC_B_ZERO,   U_WRB,      U_DIV_WAIT};
      U_DIV_WAIT: w = '{ACT_DIV_CAP, JC_DIV_DONE, U_WRB,      U_DIV_WAIT};
      U_WRB:      w = '{ACT_WRB,     JC_ALWAYS,   U_END,      U_END};
      U_END:      w = '{ACT_RD_TOP,  JC_LAST,     U_FIN,      U_IDLE};
      U_FIN:      w = '{ACT_EMIT,    JC_OUT_FREE, U_IDLE,     U_FIN};
      default:    w = '{ACT_NONE,    JC_ALWAYS,   U_IDLE,     U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rpn_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for widths and the control/status structs.
`default_nettype none

module rpn_div import rpn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output div_sts_t          sts_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    dmag_q, dmag_d;
  logic                 neg_q, neg_d;
  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    diff;

  // One restoring step
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dmag_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      dmag_d = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d  = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      rem_d = diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], ~diff[DATA_W+1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  // Apply sign of the quotient
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

// File: rtl/rpn_stack_evaluator_core.sv
// RPN stack evaluator: a microcoded sequencer over an operand stack memory.
// Per token: a push writes the stack; add/sub/mul read both operands through the
// registered stack memory port, then compute and write back; a divide also waits
// on the one-bit-per-cycle divider. A last token adds an emit step, held on stall.
// Reset clears depth, sticky status and sequencer; stack contents are left as is.
// Depends on rpn_pkg and rpn_div.
`default_nettype none

module rpn_stack_evaluator_core import rpn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  uaddr_e              upc_q, upc_d;
  ucw_t                uw;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [2:0]          status_q, status_d;
  in_t                 tok_q;
  logic [DATA_W-1:0]   b_q;
  logic [DATA_W-1:0]   res_q, res_d;
  logic [DATA_W-1:0]   rd_data_q;
  logic                out_valid_q;
  out_t                out_q;
  logic                in_fire, out_free, cond;
  logic                rd_en, wr_en;
  logic [PTR_W-1:0]    rd_addr, wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [DEPTH_W-1:0]  depth_m1, depth_m2;
  logic                is_op;
  logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [DATA_W-1:0]   quotient;

  assign uw        = ucode(upc_q);
  assign in_stall_o = (upc_q != U_IDLE);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign depth_m1  = depth_q - 1'b1;
  assign depth_m2  = depth_q - DEPTH_W'(2);
  assign is_op     = (tok_q.command >= CMD_ADD) && (tok_q.command <= CMD_DIV);

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (rd_data_q),
    .divisor_i  (b_q),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  // Select jump condition and next step
  always_comb begin
    case (uw.jc)
      JC_ALWAYS:   cond = 1'b1;
      JC_IN_FIRE:  cond = in_fire;
      JC_IS_DIV:   cond = (tok_q.command == CMD_DIV);
      JC_B_ZERO:   cond = (b_q == '0);
      JC_DIV_DONE: cond = div_sts.done;
      JC_LAST:     cond = tok_q.last_token;
      JC_OUT_FREE: cond = out_free;
      default:     cond = 1'b0;
    endcase
    if (uw.jc == JC_DISPATCH) begin
      if (tok_q.command == CMD_PUSH) begin
        upc_d = U_PUSH;
      end else if (is_op) begin
        upc_d = (depth_q < DEPTH_W'(2)) ? U_UNDER : U_RD_B;
      end else begin
        upc_d = U_END;
      end
    end else begin
      upc_d = cond ? uw.target : uw.next;
    end
  end

  // Decode the step action into datapath controls
  always_comb begin
    depth_d       = depth_q;
    status_d      = status_q;
    res_d         = res_q;
    rd_en         = 1'b0;
    rd_addr       = depth_m1[PTR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = depth_m2[PTR_W-1:0];
    wr_data       = res_q;
    div_ctl.start = 1'b0;
    unique case (uw.act)
      ACT_PUSH: begin
        if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
          status_d = (status_q == ST_OK) ? ST_OVERFLOW : status_q;
        end else begin
          wr_en   = 1'b1;
          wr_addr = depth_q[PTR_W-1:0];
          wr_data = tok_q.number;
          depth_d = depth_q + 1'b1;
        end
      end
      ACT_UNDER: status_d = (status_q == ST_OK) ? ST_UNDERFLOW : status_q;
      ACT_RD_B:  rd_en = 1'b1;
      ACT_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = depth_m2[PTR_W-1:0];
      end
      ACT_ALU: begin
        case (tok_q.command)
          CMD_ADD: res_d = rd_data_q + b_q;
          CMD_SUB: res_d = rd_data_q - b_q;
          CMD_MUL: res_d = rd_data_q * b_q;
          default: res_d = res_q;
        endcase
      end
      ACT_DIV_CHK: begin
        if (b_q == '0) begin
          status_d = (status_q == ST_OK) ? ST_DIVZERO : status_q;
          res_d    = '0;
        end else begin
          div_ctl.start = 1'b1;
        end
      end
      ACT_DIV_CAP: begin
        if (div_sts.done) begin
          res_d = quotient;
        end
      end
      ACT_WRB: begin
        wr_en   = 1'b1;
        depth_d = depth_m1;
      end
      ACT_RD_TOP: rd_en = 1'b1;
      ACT_EMIT: begin
        if (out_free) begin
          depth_d  = '0;
          status_d = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Hold sequencer, depth, status and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      depth_q     <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      depth_q  <= depth_d;
      status_q <= status_d;
      if (uw.act == ACT_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold token, operands and result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_fire) begin
      tok_q <= in_data_i;
    end
    if (uw.act == ACT_RD_A) begin
      b_q <= rd_data_q;
    end
    if (uw.act == ACT_EMIT && out_free) begin
      out_q.value  <= (depth_q != '0) ? rd_data_q : '0;
      out_q.status <= (status_q != ST_OK) ? status_q :
                      ((depth_q != DEPTH_W'(1)) ? ST_BADDEPTH : ST_OK);
    end
  end

  // Operand stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_emit_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q) == U_FIN)
    else $error("result raised outside the final step");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> upc_q == U_DIV_WAIT)
    else $error("divider finished while sequencer not waiting");

  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire
